/* sv/sgdmf_pkg.sv */
// sgdmf_pkg: shared constants, types and saturation helpers for the
// latent-factor update engine; no dependencies
package sgdmf_pkg;

   localparam int LATENT_SIZE = 2;
   localparam int ITEM_ROWS   = 1024;
   localparam int USER_ROWS   = 4096;

   localparam int EL_W     = (LATENT_SIZE > 1) ? $clog2(LATENT_SIZE) : 1;
   localparam int ITEM_AW  = $clog2(ITEM_ROWS * LATENT_SIZE);
   localparam int USER_AW  = $clog2(USER_ROWS * LATENT_SIZE);
   localparam int ITEM_DEPTH = ITEM_ROWS * LATENT_SIZE;
   localparam int USER_DEPTH = USER_ROWS * LATENT_SIZE;

   localparam int Q_SHIFT = 24;
   localparam int CFG_W   = 25;
   localparam int WIDE_W  = 48;   // accumulator, error and sum width
   localparam int GRAD_W  = 38;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_UPDATE  = 2'd1;
   localparam logic [1:0] OP_PREDICT = 2'd2;

   localparam logic [0:0] REG_STEP = 1'b0;
   localparam logic [0:0] REG_REG  = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] learn_rate;
      logic [CFG_W-1:0] regularization;
   } cfg_type;

   localparam logic signed [WIDE_W-1:0] S32_MAX = WIDE_W'(64'sd2147483647);
   localparam logic signed [WIDE_W-1:0] S32_MIN = -WIDE_W'(64'sd2147483648);
   localparam logic signed [WIDE_W-1:0] G_MAX   = WIDE_W'(64'sd137438953471);
   localparam logic signed [WIDE_W-1:0] G_MIN   = -WIDE_W'(64'sd137438953472);

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      if (v > S32_MAX) return 32'sh7fffffff;
      else if (v < S32_MIN) return 32'sh80000000;
      else return v[31:0];
   endfunction

   function automatic logic clip32(input logic signed [WIDE_W-1:0] v);
      return (v > S32_MAX) || (v < S32_MIN);
   endfunction

   function automatic logic signed [GRAD_W-1:0] satg(input logic signed [WIDE_W-1:0] v);
      if (v > G_MAX) return G_MAX[GRAD_W-1:0];
      else if (v < G_MIN) return G_MIN[GRAD_W-1:0];
      else return v[GRAD_W-1:0];
   endfunction

   function automatic logic clipg(input logic signed [WIDE_W-1:0] v);
      return (v > G_MAX) || (v < G_MIN);
   endfunction

endpackage

/* sv/sgdmf_ram.sv */
// sgdmf_ram: generic single-port synchronous ram with registered read
// no dependencies
module sgdmf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

/* sv/sgdmf_csr.sv */
// sgdmf_csr: apb-style register file for learning rate and regularization
// depends on sgdmf_pkg
module sgdmf_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output sgdmf_pkg::cfg_type   cfg
);
   sgdmf_pkg::cfg_type cfg_ff, cfg_in;
   logic wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_paddr[2])
            sgdmf_pkg::REG_STEP: cfg_in.learn_rate = csr_pwdata[sgdmf_pkg::CFG_W-1:0];
            sgdmf_pkg::REG_REG:  cfg_in.regularization = csr_pwdata[sgdmf_pkg::CFG_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learn_rate     <= sgdmf_pkg::CFG_W'(13245);
         cfg_ff.regularization <= sgdmf_pkg::CFG_W'(16777);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         sgdmf_pkg::REG_STEP: csr_prdata = {7'd0, cfg_ff.learn_rate};
         sgdmf_pkg::REG_REG:  csr_prdata = {7'd0, cfg_ff.regularization};
         default:             csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

/* sv/sgd_matrix_factor_update.sv */
// sgd_matrix_factor_update: top level, sequencer and arithmetic of the engine
// depends on sgdmf_pkg, sgdmf_ram, sgdmf_csr
//
// Latent-factor engine for matrix factorization trained by stochastic gradient
// descent. Item and user latent rows (Q8.24 elements) live in two single-port
// rams, addressed row*LATENT_SIZE+element; their contents are undefined until
// loaded. One item is worked on at a time: a load writes the ram as it is
// accepted and goes straight to the result; a predict reads, multiplies and
// accumulates each element through the registered ram read, then forms the
// error; an update adds per element two gradient products, two step products
// and two write-backs. After the result is posted the engine returns to idle,
// where the next item can be accepted. Writes
// of one item finish before the next item is read, so no forwarding is needed.
// A result waits in an output register while the next item is accepted. Sums,
// gradients and elements saturate and raise the saturated flag.
module sgd_matrix_factor_update (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // item_index[9:0] user_index[21:10] rating[29:22] load_user_side[30]
   // element_index[31] element_value[63:32]
   input  logic [63:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // prediction[31:0] error_value[63:32]
   output logic [63:0] rsp_tdata,
   // saturated[0]
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int L  = sgdmf_pkg::LATENT_SIZE;
   localparam int EW = sgdmf_pkg::EL_W;
   localparam int IW = sgdmf_pkg::ITEM_AW;
   localparam int UW = sgdmf_pkg::USER_AW;
   localparam int WW = sgdmf_pkg::WIDE_W;
   localparam int GW = sgdmf_pkg::GRAD_W;
   localparam int QS = sgdmf_pkg::Q_SHIFT;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD   = 4'd1;
   localparam logic [3:0] S_MUL  = 4'd2;
   localparam logic [3:0] S_ACC  = 4'd3;
   localparam logic [3:0] S_ERR  = 4'd4;
   localparam logic [3:0] S_G1   = 4'd5;
   localparam logic [3:0] S_G2   = 4'd6;
   localparam logic [3:0] S_G3   = 4'd7;
   localparam logic [3:0] S_G4   = 4'd8;
   localparam logic [3:0] S_G5   = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;

   sgdmf_pkg::cfg_type cfg;

   sgdmf_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   // request fields
   logic [9:0]  f_item;
   logic [11:0] f_user;
   logic [7:0]  f_rating;
   logic        f_side;
   logic        f_el;
   logic [31:0] f_value;
   assign f_item   = req_tdata[9:0];
   assign f_user   = req_tdata[21:10];
   assign f_rating = req_tdata[29:22];
   assign f_side   = req_tdata[30];
   assign f_el     = req_tdata[31];
   assign f_value  = req_tdata[63:32];

   logic [3:0]  state_ff, state_in;
   logic [1:0]  op_ff;
   logic [IW-1:0] ibase_ff;
   logic [UW-1:0] ubase_ff;
   logic [7:0]  rating_ff;
   logic [EW-1:0] k_ff, k_in;
   logic signed [31:0] m_ff [L];
   logic signed [31:0] u_ff [L];
   logic signed [63:0] p1_ff;
   logic signed [63:0] p2_ff;
   logic signed [WW-1:0] sum_ff;
   logic signed [31:0] pred_ff, err_ff;
   logic        flag_ff;
   logic signed [GW-1:0] gm_ff;
   logic signed [GW-1:0] gu_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff;
   logic        rsp_flag_ff;

   logic accept;
   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;

   // ram ports
   logic          i_we, u_we;
   logic [IW-1:0] i_addr;
   logic [UW-1:0] u_addr;
   logic [31:0]   i_wdata, u_wdata, i_rdata, u_rdata;

   sgdmf_ram #(.WIDTH(32), .DEPTH(sgdmf_pkg::ITEM_DEPTH)) u_item_ram (
      .clock, .we(i_we), .addr(i_addr), .wdata(i_wdata), .rdata(i_rdata)
   );
   sgdmf_ram #(.WIDTH(32), .DEPTH(sgdmf_pkg::USER_DEPTH)) u_user_ram (
      .clock, .we(u_we), .addr(u_addr), .wdata(u_wdata), .rdata(u_rdata)
   );

   // row bases of the incoming item, rows wrap at table size
   logic [IW-1:0] in_ibase;
   logic [UW-1:0] in_ubase;
   logic          load_ok;
   assign in_ibase = IW'((32'(f_item) % sgdmf_pkg::ITEM_ROWS) * L);
   assign in_ubase = UW'((32'(f_user) % sgdmf_pkg::USER_ROWS) * L);
   assign load_ok  = (32'(f_el) < L);

   // element updates of the write-back steps
   logic signed [WW-1:0] step_s, lam_s, new_m, new_u;
   logic signed [WW-1:0] gsum;
   logic signed [WW-1:0] err_w;
   assign step_s = WW'($signed({1'b0, cfg.learn_rate}));
   assign lam_s  = WW'($signed({1'b0, cfg.regularization}));
   assign gsum   = WW'(p1_ff >>> QS) - WW'(p2_ff >>> QS);
   assign new_m  = WW'(m_ff[k_ff]) + WW'(p1_ff >>> QS);
   assign new_u  = WW'(u_ff[k_ff]) + WW'(p1_ff >>> QS);
   assign err_w  = $signed(WW'({rating_ff, 24'd0})) - sum_ff;

   always_comb begin
      i_we = 1'b0;
      u_we = 1'b0;
      i_addr = ibase_ff + IW'(k_ff);
      u_addr = ubase_ff + UW'(k_ff);
      i_wdata = f_value;
      u_wdata = f_value;
      state_in = state_ff;
      k_in = k_ff;
      case (state_ff)
         S_IDLE: begin
            i_addr = in_ibase + IW'(f_el);
            u_addr = in_ubase + UW'(f_el);
            if (accept) begin
               k_in = '0;
               if (req_tuser == sgdmf_pkg::OP_LOAD) begin
                  i_we = load_ok && !f_side;
                  u_we = load_ok && f_side;
                  state_in = S_DONE;
               end else if (req_tuser == sgdmf_pkg::OP_UPDATE ||
                            req_tuser == sgdmf_pkg::OP_PREDICT) begin
                  state_in = S_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_RD:  state_in = S_MUL;
         S_MUL: state_in = S_ACC;
         S_ACC: begin
            if (32'(k_ff) == L - 1) begin
               state_in = S_ERR;
            end else begin
               k_in = k_ff + EW'(1);
               state_in = S_RD;
            end
         end
         S_ERR: begin
            k_in = '0;
            state_in = (op_ff == sgdmf_pkg::OP_UPDATE) ? S_G1 : S_DONE;
         end
         S_G1: state_in = S_G2;
         S_G2: state_in = S_G3;
         S_G3: state_in = S_G4;
         S_G4: begin
            i_we = 1'b1;
            i_wdata = sgdmf_pkg::sat32(new_m);
            state_in = S_G5;
         end
         S_G5: begin
            u_we = 1'b1;
            u_wdata = sgdmf_pkg::sat32(new_u);
            if (32'(k_ff) == L - 1) begin
               state_in = S_DONE;
            end else begin
               k_in = k_ff + EW'(1);
               state_in = S_G1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
         flag_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: if (accept) flag_ff <= 1'b0;
            S_ERR:  flag_ff <= flag_ff || sgdmf_pkg::clip32(sum_ff)
                                       || sgdmf_pkg::clip32(err_w);
            S_G2, S_G3: flag_ff <= flag_ff || sgdmf_pkg::clipg(gsum);
            S_G4:   flag_ff <= flag_ff || sgdmf_pkg::clip32(new_m);
            S_G5:   flag_ff <= flag_ff || sgdmf_pkg::clip32(new_u);
            default: flag_ff <= flag_ff;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_ff <= req_tuser;
               ibase_ff <= in_ibase;
               ubase_ff <= in_ubase;
               rating_ff <= f_rating;
               sum_ff <= '0;
               pred_ff <= '0;
               err_ff <= '0;
            end
         end
         S_MUL: begin
            m_ff[k_ff] <= $signed(i_rdata);
            u_ff[k_ff] <= $signed(u_rdata);
            p1_ff <= $signed(i_rdata) * $signed(u_rdata);
         end
         S_ACC: sum_ff <= sum_ff + WW'(p1_ff >>> QS);
         S_ERR: begin
            pred_ff <= sgdmf_pkg::sat32(sum_ff);
            err_ff  <= sgdmf_pkg::sat32(err_w);
         end
         // gradient of the item element: e*u - lambda*m
         S_G1: begin
            p1_ff <= 64'(err_ff) * 64'(u_ff[k_ff]);
            p2_ff <= 64'(lam_s) * 64'(m_ff[k_ff]);
         end
         // keep the item gradient, gradient of the user element: e*m - lambda*u
         S_G2: begin
            gm_ff <= sgdmf_pkg::satg(gsum);
            p1_ff <= 64'(err_ff) * 64'(m_ff[k_ff]);
            p2_ff <= 64'(lam_s) * 64'(u_ff[k_ff]);
         end
         // keep the user gradient, step product of the item element
         S_G3: begin
            gu_ff <= sgdmf_pkg::satg(gsum);
            p1_ff <= 64'(step_s) * 64'(gm_ff);
         end
         // step product of the user element
         S_G4: p1_ff <= 64'(step_s) * 64'(gu_ff);
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_ff <= {err_ff, pred_ff};
               rsp_flag_ff <= flag_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flag_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request taken while busy");
   a_elem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (32'(k_ff) < L))
      else $error("element counter out of range");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == S_DONE))
      else $error("result posted outside done step");
endmodule
